// File: rtl/fvm_pkg.sv
package fvm_pkg;

    localparam int FRAC      = 20;
    localparam int DIV_LAT   = 16;
    localparam int DIV_STEP  = 2;
    localparam int SQRT_LAT  = 13;
    localparam int SQRT_STEP = 2;
    localparam int ROOT_W    = 26;
    localparam int REM_W     = 29;
    localparam int SQX_W     = 52;

    localparam logic signed [63:0] RND_BIAS = 64'sd1048575;
    localparam logic signed [63:0] ONE_WIDE = 64'sd1048576;
    localparam logic [30:0]        ONE_U    = 31'd1048576;
    localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;

    // metric entry for row a, column b (xx, xy, xz, yy, yz, zz)
    localparam int GIDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

    typedef enum logic [1:0] {
        MODE_FLUID = 2'd0,
        MODE_MIXED = 2'd1,
        MODE_ZERO  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic {
        REG_MODE  = 1'b0,
        REG_FLOOR = 1'b1
    } reg_idx_t;

    typedef logic [30:0]       uq_t;
    typedef logic [2:0][31:0]  vec_t;
    typedef logic [5:0][31:0]  met_t;

    typedef struct packed {
        logic written;
        uq_t  lorentz;
        vec_t up;
        vec_t dn;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > S32_MAX)
        begin
            return 32'sh7fffffff;
        end
        else if (x < S32_MIN)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // q12.20 product: truncate toward zero, then saturate
    function automatic logic signed [31:0] qprod(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (p[63] ? RND_BIAS : 64'sd0);
        return sat32(t >>> FRAC);
    endfunction

    function automatic logic signed [31:0] sum3(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic signed [31:0] c);
        return sat32(64'(a) + 64'(b) + 64'(c));
    endfunction

endpackage

// File: rtl/fiducial_velocity_from_metric_unit.sv
// throughput: one beat per cycle while the skid stage is empty; 59 register stages, set by
// two 16-stage dividers and a 13-stage square root, with an output register and skid stage
// at the end
// reset: async active low clears valid bits, mode to fluid and density floor to 1
module fiducial_velocity_from_metric_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  fvm_pkg::reg_idx_t     cfg_index,
    input  logic [30:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    util_x,
    input  logic signed [31:0]    util_y,
    input  logic signed [31:0]    util_z,
    input  logic signed [31:0]    g_xx,
    input  logic signed [31:0]    g_xy,
    input  logic signed [31:0]    g_xz,
    input  logic signed [31:0]    g_yy,
    input  logic signed [31:0]    g_yz,
    input  logic signed [31:0]    g_zz,
    input  logic [30:0]           density,
    input  logic [30:0]           lorentz_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  written,
    output logic [30:0]           lorentz_out,
    output logic signed [31:0]    vel_up_x,
    output logic signed [31:0]    vel_up_y,
    output logic signed [31:0]    vel_up_z,
    output logic signed [31:0]    vel_down_x,
    output logic signed [31:0]    vel_down_y,
    output logic signed [31:0]    vel_down_z
);
    import fvm_pkg::*;

    localparam int PIPE_LEN = 2 + DIV_LAT + 1 + 6 + SQRT_LAT + 1 + DIV_LAT + 1 + 3;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SQX_W-1:0]  x;
    } sq_t;

    function automatic sq_t sq_step(input sq_t s);
        sq_t              n;
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] t;
        r   = {s.rem[REM_W-3:0], s.x[SQX_W-1 -: 2]};
        t   = {1'b0, s.root, 2'b01};
        n.x = {s.x[SQX_W-3:0], 2'b00};
        if (r >= t)
        begin
            n.rem  = r - t;
            n.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = r;
            n.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic sq_t sq_stage(input sq_t s);
        sq_t n;
        n = s;
        for (int k = 0; k < SQRT_STEP; k++)
        begin
            n = sq_step(n);
        end
        return n;
    endfunction

    mode_t mode_reg;
    uq_t   floor_reg;

    logic                en;
    logic [PIPE_LEN:1]   vld_reg;
    logic                skid_valid_reg;
    logic                out_valid_reg;
    res_t                skid_reg;
    res_t                out_reg;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FLUID;
            floor_reg <= 31'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= mode_t'(cfg_data[1:0]);
                REG_FLOOR: floor_reg <= cfg_data;
                default:   floor_reg <= floor_reg;
            endcase
        end
    end

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LEN-1:1], in_valid};
        end
    end

    // stage 1: capture
    vec_t s1_u;
    met_t s1_g;
    uq_t  s1_lin;
    uq_t  s1_rho;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u   <= {util_z, util_y, util_x};
            s1_g   <= {g_zz, g_yz, g_yy, g_xz, g_xy, g_xx};
            s1_lin <= lorentz_in;
            s1_rho <= density;
        end
    end

    // stage 2: |u| * rho for density weighting
    uq_t              den1;
    logic [2:0][31:0] au1;
    vec_t             s2_u;
    met_t             s2_g;
    uq_t              s2_lin;
    uq_t              s2_den;
    logic             s2_dz;
    logic [2:0][62:0] s2_prod;

    always_comb
    begin
        den1 = (s1_rho > floor_reg) ? s1_rho : floor_reg;
        for (int i = 0; i < 3; i++)
        begin
            au1[i] = s1_u[i][31] ? (32'd0 - s1_u[i]) : s1_u[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_u   <= s1_u;
            s2_g   <= s1_g;
            s2_lin <= s1_lin;
            s2_den <= den1;
            s2_dz  <= (den1 == '0);
            for (int i = 0; i < 3; i++)
            begin
                s2_prod[i] <= au1[i] * s1_rho;
            end
        end
    end

    // density scaling divide
    logic [2:0][31:0] qa;

    for (genvar i = 0; i < 3; i++)
    begin : g_div_a
        fvm_div u_div_a (
            .clk      (clk),
            .en       (en),
            .dividend (s2_prod[i]),
            .divisor  (s2_den),
            .quotient (qa[i])
        );
    end

    vec_t da_u   [DIV_LAT];
    met_t da_g   [DIV_LAT];
    uq_t  da_lin [DIV_LAT];
    logic da_dz  [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            da_u[0]   <= s2_u;
            da_g[0]   <= s2_g;
            da_lin[0] <= s2_lin;
            da_dz[0]  <= s2_dz;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                da_u[k]   <= da_u[k-1];
                da_g[k]   <= da_g[k-1];
                da_lin[k] <= da_lin[k-1];
                da_dz[k]  <= da_dz[k-1];
            end
        end
    end

    // scaled u
    vec_t us;
    vec_t s19_u;
    met_t s19_g;
    uq_t  s19_lin;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (mode_reg != MODE_MIXED)
            begin
                us[i] = da_u[DIV_LAT-1][i];
            end
            else if (da_dz[DIV_LAT-1])
            begin
                us[i] = '0;
            end
            else if (da_u[DIV_LAT-1][i][31])
            begin
                us[i] = 32'd0 - qa[i];
            end
            else
            begin
                us[i] = qa[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s19_u   <= us;
            s19_g   <= da_g[DIV_LAT-1];
            s19_lin <= da_lin[DIV_LAT-1];
        end
    end

    // g * u, three stages
    logic signed [63:0] m1_p [3][3];
    logic signed [31:0] m2_q [3][3];
    vec_t s20_u, s21_u, s22_u;
    met_t s20_g, s21_g, s22_g;
    uq_t  s20_lin, s21_lin, s22_lin;
    vec_t s22_gu;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    m1_p[a][b] <= $signed(s19_g[GIDX[a][b]]) * $signed(s19_u[b]);
                    m2_q[a][b] <= qprod(m1_p[a][b]);
                end
                s22_gu[a] <= sum3(m2_q[a][0], m2_q[a][1], m2_q[a][2]);
            end
            s20_u   <= s19_u;
            s20_g   <= s19_g;
            s20_lin <= s19_lin;
            s21_u   <= s20_u;
            s21_g   <= s20_g;
            s21_lin <= s20_lin;
            s22_u   <= s21_u;
            s22_g   <= s21_g;
            s22_lin <= s21_lin;
        end
    end

    // norm u . gu, three stages
    logic signed [63:0] n1_p [3];
    logic signed [31:0] n2_q [3];
    vec_t s23_u, s24_u, s25_u;
    met_t s23_g, s24_g, s25_g;
    uq_t  s23_lin, s24_lin, s25_lin;
    logic signed [31:0] norm_raw;
    logic signed [31:0] norm_pos;
    logic signed [31:0] rad_full;
    uq_t                s25_rad;

    always_comb
    begin
        norm_raw = sum3(n2_q[0], n2_q[1], n2_q[2]);
        norm_pos = norm_raw[31] ? 32'sd0 : norm_raw;
        rad_full = sat32(64'(norm_pos) + ONE_WIDE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                n1_p[a] <= $signed(s22_u[a]) * $signed(s22_gu[a]);
                n2_q[a] <= qprod(n1_p[a]);
            end
            s23_u   <= s22_u;
            s23_g   <= s22_g;
            s23_lin <= s22_lin;
            s24_u   <= s23_u;
            s24_g   <= s23_g;
            s24_lin <= s23_lin;
            s25_u   <= s24_u;
            s25_g   <= s24_g;
            s25_lin <= s24_lin;
            s25_rad <= rad_full[30:0];
        end
    end

    // square root, two digits per stage
    sq_t  sq_init;
    sq_t  sq_reg [SQRT_LAT];
    vec_t sq_u   [SQRT_LAT];
    met_t sq_g   [SQRT_LAT];
    uq_t  sq_lin [SQRT_LAT];

    assign sq_init = '{rem: '0, root: '0, x: {1'b0, s25_rad, 20'd0}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= sq_stage(sq_init);
            sq_u[0]   <= s25_u;
            sq_g[0]   <= s25_g;
            sq_lin[0] <= s25_lin;
            for (int k = 1; k < SQRT_LAT; k++)
            begin
                sq_reg[k] <= sq_stage(sq_reg[k-1]);
                sq_u[k]   <= sq_u[k-1];
                sq_g[k]   <= sq_g[k-1];
                sq_lin[k] <= sq_lin[k-1];
            end
        end
    end

    // pick W, set up u / W
    uq_t              w_sel;
    logic [2:0][31:0] au2;
    logic [2:0]       ovf2;
    vec_t             s39_u;
    met_t             s39_g;
    uq_t              s39_w;
    logic [2:0]       s39_ovf;
    logic [2:0][62:0] s39_dvd;

    always_comb
    begin
        w_sel = (mode_reg == MODE_FLUID) ? sq_lin[SQRT_LAT-1]
                                         : {5'd0, sq_reg[SQRT_LAT-1].root};
        for (int i = 0; i < 3; i++)
        begin
            au2[i]  = sq_u[SQRT_LAT-1][i][31] ? (32'd0 - sq_u[SQRT_LAT-1][i])
                                              : sq_u[SQRT_LAT-1][i];
            ovf2[i] = (au2[i] != '0) && ({11'd0, au2[i][31:12]} >= w_sel);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s39_u   <= sq_u[SQRT_LAT-1];
            s39_g   <= sq_g[SQRT_LAT-1];
            s39_w   <= w_sel;
            s39_ovf <= ovf2;
            for (int i = 0; i < 3; i++)
            begin
                s39_dvd[i] <= {11'd0, au2[i], 20'd0};
            end
        end
    end

    logic [2:0][31:0] qb;

    for (genvar i = 0; i < 3; i++)
    begin : g_div_b
        fvm_div u_div_b (
            .clk      (clk),
            .en       (en),
            .dividend (s39_dvd[i]),
            .divisor  (s39_w),
            .quotient (qb[i])
        );
    end

    vec_t       db_u   [DIV_LAT];
    met_t       db_g   [DIV_LAT];
    uq_t        db_w   [DIV_LAT];
    logic [2:0] db_ovf [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            db_u[0]   <= s39_u;
            db_g[0]   <= s39_g;
            db_w[0]   <= s39_w;
            db_ovf[0] <= s39_ovf;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                db_u[k]   <= db_u[k-1];
                db_g[k]   <= db_g[k-1];
                db_w[k]   <= db_w[k-1];
                db_ovf[k] <= db_ovf[k-1];
            end
        end
    end

    // signed, saturated v
    vec_t v56;
    vec_t s56_v;
    met_t s56_g;
    uq_t  s56_w;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (db_u[DIV_LAT-1][i] == '0)
            begin
                v56[i] = '0;
            end
            else if (db_ovf[DIV_LAT-1][i])
            begin
                v56[i] = db_u[DIV_LAT-1][i][31] ? 32'h80000000 : 32'h7fffffff;
            end
            else if (!db_u[DIV_LAT-1][i][31])
            begin
                v56[i] = (qb[i] > 32'h7fffffff) ? 32'h7fffffff : qb[i];
            end
            else
            begin
                v56[i] = (qb[i] > 32'h80000000) ? 32'h80000000 : (32'd0 - qb[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s56_v <= v56;
            s56_g <= db_g[DIV_LAT-1];
            s56_w <= db_w[DIV_LAT-1];
        end
    end

    // lower v, three stages, then mode override
    logic signed [63:0] l1_p [3][3];
    logic signed [31:0] l2_q [3][3];
    vec_t s57_v, s58_v;
    uq_t  s57_w, s58_w;
    res_t res58;
    res_t s59_res;

    always_comb
    begin
        res58.written = 1'b1;
        res58.lorentz = s58_w;
        res58.up      = s58_v;
        for (int a = 0; a < 3; a++)
        begin
            res58.dn[a] = sum3(l2_q[a][0], l2_q[a][1], l2_q[a][2]);
        end
        case (mode_reg)
            MODE_ZERO:
            begin
                res58.lorentz = ONE_U;
                res58.up      = '0;
                res58.dn      = '0;
            end
            MODE_NONE:
            begin
                res58 = '0;
            end
            default:
            begin
                res58.written = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    l1_p[a][b] <= $signed(s56_g[GIDX[a][b]]) * $signed(s56_v[b]);
                    l2_q[a][b] <= qprod(l1_p[a][b]);
                end
            end
            s57_v   <= s56_v;
            s57_w   <= s56_w;
            s58_v   <= s57_v;
            s58_w   <= s57_w;
            s59_res <= res58;
        end
    end

    // output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= vld_reg[PIPE_LEN];
            end
        end
        else if (en && vld_reg[PIPE_LEN])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : s59_res;
        end
        else if (en)
        begin
            skid_reg <= s59_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign written     = out_reg.written;
    assign lorentz_out = out_reg.lorentz;
    assign vel_up_x    = out_reg.up[0];
    assign vel_up_y    = out_reg.up[1];
    assign vel_up_z    = out_reg.up[2];
    assign vel_down_x  = out_reg.dn[0];
    assign vel_down_y  = out_reg.dn[1];
    assign vel_down_z  = out_reg.dn[2];

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held with empty output register");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without output stall");

    a_unwritten_only_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !written) |-> (mode_reg == MODE_NONE))
        else $error("unwritten beat outside none mode");

    a_zero_mode_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg == MODE_ZERO) |-> (lorentz_out == ONE_U))
        else $error("zero mode beat with lorentz factor not one");

endmodule

// File: rtl/fvm_div.sv
module fvm_div (
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] dividend,
    input  logic [30:0] divisor,
    output logic [31:0] quotient
);
    import fvm_pkg::*;

    typedef struct packed {
        logic [30:0] rem;
        logic [31:0] lo;
        logic [31:0] quo;
        logic [30:0] dvs;
    } div_t;

    function automatic div_t div_step(input div_t s);
        div_t        n;
        logic [31:0] r;
        r    = {s.rem, s.lo[31]};
        n    = s;
        n.lo = {s.lo[30:0], 1'b0};
        if (r >= {1'b0, s.dvs})
        begin
            n.rem = 31'(r - {1'b0, s.dvs});
            n.quo = {s.quo[30:0], 1'b1};
        end
        else
        begin
            n.rem = r[30:0];
            n.quo = {s.quo[30:0], 1'b0};
        end
        return n;
    endfunction

    function automatic div_t div_stage(input div_t s);
        div_t n;
        n = s;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            n = div_step(n);
        end
        return n;
    endfunction

    div_t stage_reg [DIV_LAT];
    div_t init;

    assign init = '{rem: dividend[62:32], lo: dividend[31:0], quo: 32'd0, dvs: divisor};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= div_stage(init);
            for (int k = 1; k < DIV_LAT; k++)
            begin
                stage_reg[k] <= div_stage(stage_reg[k-1]);
            end
        end
    end

    assign quotient = stage_reg[DIV_LAT-1].quo;

endmodule

// File: bench/fvm_checker.sv
`timescale 1ns / 100ps

module fvm_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  fvm_pkg::reg_idx_t  cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] util_x,
    input  logic signed [31:0] util_y,
    input  logic signed [31:0] util_z,
    input  logic signed [31:0] g_xx,
    input  logic signed [31:0] g_xy,
    input  logic signed [31:0] g_xz,
    input  logic signed [31:0] g_yy,
    input  logic signed [31:0] g_yz,
    input  logic signed [31:0] g_zz,
    input  logic [30:0]        density,
    input  logic [30:0]        lorentz_in,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               written,
    input  logic [30:0]        lorentz_out,
    input  logic signed [31:0] vel_up_x,
    input  logic signed [31:0] vel_up_y,
    input  logic signed [31:0] vel_up_z,
    input  logic signed [31:0] vel_down_x,
    input  logic signed [31:0] vel_down_y,
    input  logic signed [31:0] vel_down_z,
    output int                 pending,
    output int                 errors,
    output int                 cells_checked
);
    import fvm_pkg::*;

    localparam longint UNIT = 64'sd1048576;
    localparam longint POS_LIMIT = 64'sd2147483647;
    localparam longint NEG_LIMIT = -64'sd2147483648;

    typedef struct packed {
        logic               written;
        logic [30:0]        lorentz;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic signed [31:0] dn_x;
        logic signed [31:0] dn_y;
        logic signed [31:0] dn_z;
    } velocity_t;

    mode_t       cur_mode;
    logic [30:0] cur_floor;
    velocity_t   expected_velocities[$];

    function automatic longint clamp32(input longint x);
        if (x > POS_LIMIT)
        begin
            return POS_LIMIT;
        end
        if (x < NEG_LIMIT)
        begin
            return NEG_LIMIT;
        end
        return x;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return clamp32((a * b) / UNIT);
    endfunction

    function automatic longint fix_div(input longint u, input longint w);
        if (w == 0)
        begin
            return (u > 0) ? POS_LIMIT : (u < 0) ? NEG_LIMIT : 0;
        end
        return clamp32((u * UNIT) / w);
    endfunction

    function automatic longint int_root(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic void lower_vec(input longint g[3][3], input longint v[3],
                                      output longint d[3]);
        for (int a = 0; a < 3; a++)
        begin
            d[a] = clamp32(fix_mul(g[a][0], v[0]) + fix_mul(g[a][1], v[1])
                           + fix_mul(g[a][2], v[2]));
        end
    endfunction

    function automatic velocity_t predict_cell();
        velocity_t r;
        longint    u[3];
        longint    g[3][3];
        longint    v[3];
        longint    vd[3];
        longint    gu[3];
        longint    w;
        longint    rho;
        longint    den;
        longint    norm;
        longint    rad;
        r = '0;
        u[0] = util_x;
        u[1] = util_y;
        u[2] = util_z;
        g[0][0] = g_xx;
        g[0][1] = g_xy;
        g[1][0] = g_xy;
        g[0][2] = g_xz;
        g[2][0] = g_xz;
        g[1][1] = g_yy;
        g[1][2] = g_yz;
        g[2][1] = g_yz;
        g[2][2] = g_zz;
        rho = longint'(density);
        if (cur_mode == MODE_NONE)
        begin
            return r;
        end
        if (cur_mode == MODE_ZERO)
        begin
            w = UNIT;
            for (int a = 0; a < 3; a++)
            begin
                v[a] = 0;
                vd[a] = 0;
            end
        end
        else if (cur_mode == MODE_FLUID)
        begin
            w = longint'(lorentz_in);
            for (int a = 0; a < 3; a++)
            begin
                v[a] = fix_div(u[a], w);
            end
            lower_vec(g, v, vd);
        end
        else
        begin
            den = (rho > longint'(cur_floor)) ? rho : longint'(cur_floor);
            for (int a = 0; a < 3; a++)
            begin
                u[a] = (den == 0) ? 0 : (u[a] * rho) / den;
            end
            lower_vec(g, u, gu);
            norm = clamp32(fix_mul(u[0], gu[0]) + fix_mul(u[1], gu[1])
                           + fix_mul(u[2], gu[2]));
            if (norm < 0)
            begin
                norm = 0;
            end
            rad = clamp32(UNIT + norm);
            w = int_root(rad * UNIT);
            for (int a = 0; a < 3; a++)
            begin
                v[a] = fix_div(u[a], w);
            end
            lower_vec(g, v, vd);
        end
        r.written = 1'b1;
        r.lorentz = w[30:0];
        r.up_x = v[0][31:0];
        r.up_y = v[1][31:0];
        r.up_z = v[2][31:0];
        r.dn_x = vd[0][31:0];
        r.dn_y = vd[1][31:0];
        r.dn_z = vd[2][31:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        velocity_t got;
        velocity_t want;
        if (!rst_n)
        begin
            cur_mode = MODE_FLUID;
            cur_floor = 31'd1;
            expected_velocities.delete();
            errors = 0;
            cells_checked = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_MODE)
                begin
                    cur_mode = mode_t'(cfg_data[1:0]);
                end
                else
                begin
                    cur_floor = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                expected_velocities.push_back(predict_cell());
            end
            if (out_valid && out_ready)
            begin
                got = {written, lorentz_out, vel_up_x, vel_up_y, vel_up_z,
                       vel_down_x, vel_down_y, vel_down_z};
                if (expected_velocities.size() == 0)
                begin
                    $display("%0t: unexpected beat %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_velocities.pop_front();
                    cells_checked++;
                    if (got.written !== want.written)
                    begin
                        $display("%0t: written exp %0d got %0d", $time, want.written, got.written);
                        errors++;
                    end
                    if (got.lorentz !== want.lorentz)
                    begin
                        $display("%0t: lorentz exp %h got %h", $time, want.lorentz, got.lorentz);
                        errors++;
                    end
                    if (got.up_x !== want.up_x)
                    begin
                        $display("%0t: vel_up_x exp %h got %h", $time, want.up_x, got.up_x);
                        errors++;
                    end
                    if (got.up_y !== want.up_y)
                    begin
                        $display("%0t: vel_up_y exp %h got %h", $time, want.up_y, got.up_y);
                        errors++;
                    end
                    if (got.up_z !== want.up_z)
                    begin
                        $display("%0t: vel_up_z exp %h got %h", $time, want.up_z, got.up_z);
                        errors++;
                    end
                    if (got.dn_x !== want.dn_x)
                    begin
                        $display("%0t: vel_down_x exp %h got %h", $time, want.dn_x, got.dn_x);
                        errors++;
                    end
                    if (got.dn_y !== want.dn_y)
                    begin
                        $display("%0t: vel_down_y exp %h got %h", $time, want.dn_y, got.dn_y);
                        errors++;
                    end
                    if (got.dn_z !== want.dn_z)
                    begin
                        $display("%0t: vel_down_z exp %h got %h", $time, want.dn_z, got.dn_z);
                        errors++;
                    end
                end
            end
            pending = expected_velocities.size();
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import fvm_pkg::*;

    localparam int UNIT = 1048576;
    localparam int PIPE_WAIT = 80;
    localparam int STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    reg_idx_t           cfg_index;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] util_x, util_y, util_z;
    logic signed [31:0] g_xx, g_xy, g_xz, g_yy, g_yz, g_zz;
    logic [30:0]        density;
    logic [30:0]        lorentz_in;
    logic               out_valid;
    logic               out_ready;
    logic               written;
    logic [30:0]        lorentz_out;
    logic signed [31:0] vel_up_x, vel_up_y, vel_up_z;
    logic signed [31:0] vel_down_x, vel_down_y, vel_down_z;
    int                 pending;
    int                 errors;
    int                 cells_checked;
    int                 idle_cycles;
    int                 cells_sent;
    int                 burst_left;

    fiducial_velocity_from_metric_unit DUT (.*);

    fvm_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        in_valid = 1'b0;
        {util_x, util_y, util_z, g_xx, g_xy, g_xz, g_yy, g_yz, g_zz} = '0;
        density = '0;
        lorentz_in = '0;
        out_ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver: changing stall styles plus one long hold-off while cells keep coming
    initial
    begin
        int cyc;
        int style;
        bit held;
        cyc = 0;
        style = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held && cells_sent >= 700)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            if (cyc % 50 == 0)
            begin
                style = $urandom_range(0, 2);
            end
            case (style)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic set_config(input mode_t mode, input logic [30:0] floor_val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data <= 31'(mode);
        @(posedge clk);
        cfg_index <= REG_FLOOR;
        cfg_data <= floor_val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_cell(input logic signed [31:0] ux, uy, uz,
                             input logic signed [31:0] gxx, gxy, gxz, gyy, gyz, gzz,
                             input int rho, lin);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        util_x <= ux;
        util_y <= uy;
        util_z <= uz;
        g_xx <= gxx;
        g_xy <= gxy;
        g_xz <= gxz;
        g_yy <= gyy;
        g_yz <= gyz;
        g_zz <= gzz;
        density <= 31'(rho);
        lorentz_in <= 31'(lin);
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        cells_sent++;
    endtask

    task automatic directed_cells();
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        send_cell(0, 0, 0, UNIT, 0, 0, UNIT, 0, UNIT, 0, UNIT);
        send_cell(mx, mx, mx, mx, mx, mx, mx, mx, mx, 32'h7fffffff, 32'h7fffffff);
        send_cell(mn, mn, mn, mn, mn, mn, mn, mn, mn, 0, UNIT);
        send_cell(mx, mn, 0, UNIT, 0, 0, UNIT, 0, UNIT, UNIT, UNIT);
        send_cell(UNIT, -UNIT, 0, UNIT, 0, 0, UNIT, 0, UNIT, UNIT, 0);
        send_cell(UNIT / 2, -3 * UNIT, 5, 2 * UNIT, UNIT / 4, -UNIT / 8, UNIT, 0, 3 * UNIT,
                  UNIT / 2, UNIT / 2);
        send_cell(3 * UNIT, UNIT, -UNIT, -UNIT, 0, 0, -UNIT, 0, -UNIT, 2 * UNIT, 2 * UNIT);
        send_cell(1000 * UNIT, 900 * UNIT, -800 * UNIT, 2000 * UNIT, 0, 0, 2000 * UNIT, 0,
                  2000 * UNIT, 0, 32'h7fffffff);
        send_cell(-7, 7, 1, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, 1, 1);
        send_cell(2 * UNIT, 2 * UNIT, 2 * UNIT, UNIT, 0, 0, UNIT, 0, UNIT, 32'h7fffffff,
                  3 * UNIT);
    endtask

    task automatic random_cell();
        logic signed [31:0] u[3];
        logic signed [31:0] g[6];
        int                 rho;
        int                 lin;
        if ($urandom_range(0, 4) == 0)
        begin
            foreach (u[i]) u[i] = $urandom;
            foreach (g[i]) g[i] = $urandom;
            rho = int'($urandom);
            lin = int'($urandom);
        end
        else
        begin
            foreach (u[i]) u[i] = int'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
            g[0] = UNIT + $urandom_range(0, 3 * UNIT);
            g[3] = UNIT + $urandom_range(0, 3 * UNIT);
            g[5] = UNIT + $urandom_range(0, 3 * UNIT);
            g[1] = int'($urandom_range(0, UNIT / 2)) - UNIT / 4;
            g[2] = int'($urandom_range(0, UNIT / 2)) - UNIT / 4;
            g[4] = int'($urandom_range(0, UNIT / 2)) - UNIT / 4;
            rho = int'($urandom_range(0, 4 * UNIT));
            lin = UNIT + int'($urandom_range(0, 9 * UNIT));
        end
        send_cell(u[0], u[1], u[2], g[0], g[1], g[2], g[3], g[4], g[5], rho, lin);
    endtask

    initial
    begin
        mode_t       modes[8];
        logic [30:0] floors[8];
        modes = '{MODE_FLUID, MODE_MIXED, MODE_MIXED, MODE_MIXED, MODE_ZERO, MODE_NONE,
                  MODE_FLUID, MODE_MIXED};
        floors = '{31'd1, 31'd1, 31'(UNIT), 31'h7fffffff, 31'h7fffffff, 31'(UNIT),
                   31'h7fffffff, 31'(UNIT / 3)};
        cells_sent = 0;
        burst_left = 0;
        @(posedge rst_n);
        for (int p = 0; p < 8; p++)
        begin
            set_config(modes[p], floors[p]);
            if (p < 2)
            begin
                directed_cells();
            end
            for (int k = 0; k < 200; k++)
            begin
                random_cell();
            end
            in_valid <= 1'b0;
            burst_left = 0;
            @(posedge clk);
            while (pending != 0)
            begin
                @(posedge clk);
            end
            repeat (PIPE_WAIT) @(posedge clk);
        end
        $display("sent %0d cells over 8 mode/floor settings, checked %0d results, %0d errors",
                 cells_sent, cells_checked, errors);
        if (errors == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: fiducial_velocity_from_metric_unit.f
rtl/fvm_pkg.sv
rtl/fvm_div.sv
rtl/fiducial_velocity_from_metric_unit.sv
bench/fvm_checker.sv
bench/tb.sv
